/* rtl/skt_pkg.sv */
package skt_pkg;

    localparam int DEPTH   = 128;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);

    localparam int CMD_W   = 2;
    localparam int KEY_W   = 16;
    localparam int PRICE_W = 32;
    localparam int POS_W   = 7;
    localparam int STAT_W  = 3;
    localparam int COUNT_W = 8;
    localparam int ENTRY_W = KEY_W + PRICE_W;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STAT_DUPLICATE = 3'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd2;
    localparam logic [STAT_W-1:0] STAT_FULL      = 3'd3;
    localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd4;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [PRICE_W-1:0] price;
    } skt_entry_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        skt_entry_t        wdata;
        logic [ADDR_W-1:0] raddr;
    } skt_mem_req_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [KEY_W-1:0]   key;
        logic [PRICE_W-1:0] price;
        logic [COUNT_W-1:0] count;
    } skt_result_t;

endpackage

/* rtl/sorted_key_table.sv */
// Table of up to 128 entries kept in ascending order of a 16-bit key, each
// entry carrying a 32-bit price. A command beat on the input channel (cmd,
// key, price_in, position) is taken when in_valid and in_ready are both high,
// and each command yields exactly one result beat (status, key_out,
// price_out, count_out) on the output channel.
// One command is in work at a time; in_ready is low while it runs.
// A single compare unit walks the table one entry at a time, reading and then
// checking each, until the key is found or passed, and inserts and removes
// then move the tail of the table one entry at a time, by a read and then a
// write, through the one-read, one-write table RAM. A read by position skips
// the scan and reads the entry at that position directly. The next command is
// taken only after the previous result has left the sequencer for the output
// register and the sequencer is idle again, so commands never overlap.
// Results sit in an output register, so the next command is started while a
// result waits; a stalled receiver holds out_valid and the result steady, and
// the following command stops at its end until that register frees.
// Reset empties the table at once: the entry count goes to zero, valid drops
// and no clearing pass is needed.
module sorted_key_table
    import skt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [CMD_W-1:0]    cmd,
    input  logic [KEY_W-1:0]    key,
    input  logic [PRICE_W-1:0]  price_in,
    input  logic [POS_W-1:0]    position,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STAT_W-1:0]   status,
    output logic [KEY_W-1:0]    key_out,
    output logic [PRICE_W-1:0]  price_out,
    output logic [COUNT_W-1:0]  count_out
);

    skt_mem_req_t mem_req;
    skt_entry_t   mem_rdata;
    skt_result_t  result;
    logic         result_valid;
    logic         result_take;
    logic         out_valid_reg, out_valid_next;
    skt_result_t  out_reg;

    skt_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .key          (key),
        .price_in     (price_in),
        .position     (position),
        .mem_req      (mem_req),
        .mem_rdata    (mem_rdata),
        .result       (result),
        .result_valid (result_valid),
        .result_take  (result_take)
    );

    skt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

    assign result_take = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result_valid && result_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_valid && result_take)
        begin
            out_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_reg.status;
    assign key_out   = out_reg.key;
    assign price_out = out_reg.price;
    assign count_out = out_reg.count;

endmodule

/* rtl/skt_ram.sv */
module skt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/skt_seq.sv */
module skt_seq
    import skt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [CMD_W-1:0]    cmd,
    input  logic [KEY_W-1:0]    key,
    input  logic [PRICE_W-1:0]  price_in,
    input  logic [POS_W-1:0]    position,
    output skt_mem_req_t        mem_req,
    input  skt_entry_t          mem_rdata,
    output skt_result_t         result,
    output logic                result_valid,
    input  logic                result_take
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SCAN_RD  = 4'd1;
    localparam logic [3:0] S_SCAN_CHK = 4'd2;
    localparam logic [3:0] S_READ_RD  = 4'd3;
    localparam logic [3:0] S_READ_CHK = 4'd4;
    localparam logic [3:0] S_SHIFT_RD = 4'd5;
    localparam logic [3:0] S_SHIFT_WR = 4'd6;
    localparam logic [3:0] S_PUT      = 4'd7;
    localparam logic [3:0] S_DONE     = 4'd8;

    logic [3:0]         state_reg, state_next;
    logic [CMD_W-1:0]   cmd_reg, cmd_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [PRICE_W-1:0] price_reg, price_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   stop_reg, stop_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [STAT_W-1:0]  res_status_reg, res_status_next;
    logic [KEY_W-1:0]   res_key_reg, res_key_next;
    logic [PRICE_W-1:0] res_price_reg, res_price_next;

    logic             scan_hit;
    logic             scan_miss;
    logic [CNT_W-1:0] idx_up;
    logic [CNT_W-1:0] idx_down;

    assign idx_up   = idx_reg + CNT_W'(1);
    assign idx_down = idx_reg - CNT_W'(1);

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        price_next      = price_reg;
        idx_next        = idx_reg;
        stop_next       = stop_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_key_next    = res_key_reg;
        res_price_next  = res_price_reg;
        scan_hit        = 1'b0;
        scan_miss       = 1'b0;
        mem_req.we      = 1'b0;
        mem_req.waddr   = idx_reg[ADDR_W-1:0];
        mem_req.wdata   = mem_rdata;
        mem_req.raddr   = idx_reg[ADDR_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next        = cmd;
                    key_next        = key;
                    price_next      = price_in;
                    idx_next        = '0;
                    res_status_next = STAT_OK;
                    res_key_next    = '0;
                    res_price_next  = '0;
                    state_next      = S_SCAN_RD;
                    if (cmd == CMD_REMOVE && count_reg == '0)
                    begin
                        res_status_next = STAT_EMPTY;
                        state_next      = S_DONE;
                    end
                    else if (cmd == CMD_READ)
                    begin
                        idx_next = CNT_W'(position);
                        if (CNT_W'(position) >= count_reg)
                        begin
                            res_status_next = STAT_NOT_FOUND;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_READ_RD;
                        end
                    end
                end
            end
            S_SCAN_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    scan_miss = 1'b1;
                end
                else
                begin
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                if (mem_rdata.key == key_reg)
                begin
                    scan_hit = 1'b1;
                end
                else if (mem_rdata.key > key_reg)
                begin
                    scan_miss = 1'b1;
                end
                else
                begin
                    idx_next   = idx_up;
                    state_next = S_SCAN_RD;
                end
            end
            S_READ_RD:
            begin
                state_next = S_READ_CHK;
            end
            S_READ_CHK:
            begin
                res_key_next   = mem_rdata.key;
                res_price_next = mem_rdata.price;
                state_next     = S_DONE;
            end
            S_SHIFT_RD:
            begin
                if (cmd_reg == CMD_INSERT)
                begin
                    mem_req.raddr = idx_down[ADDR_W-1:0];
                    state_next    = (idx_reg == stop_reg) ? S_PUT : S_SHIFT_WR;
                end
                else
                begin
                    mem_req.raddr = idx_up[ADDR_W-1:0];
                    if (idx_up >= count_reg)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SHIFT_WR;
                    end
                end
            end
            S_SHIFT_WR:
            begin
                mem_req.we = 1'b1;
                idx_next   = (cmd_reg == CMD_INSERT) ? idx_down : idx_up;
                state_next = S_SHIFT_RD;
            end
            S_PUT:
            begin
                mem_req.we          = 1'b1;
                mem_req.wdata.key   = key_reg;
                mem_req.wdata.price = price_reg;
                count_next          = count_reg + CNT_W'(1);
                res_key_next        = key_reg;
                res_price_next      = price_reg;
                state_next          = S_DONE;
            end
            S_DONE:
            begin
                if (result_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (scan_hit)
        begin
            case (cmd_reg)
                CMD_INSERT:
                begin
                    res_status_next = STAT_DUPLICATE;
                    state_next      = S_DONE;
                end
                CMD_REMOVE:
                begin
                    res_key_next   = mem_rdata.key;
                    res_price_next = mem_rdata.price;
                    state_next     = S_SHIFT_RD;
                end
                default:
                begin
                    res_key_next   = mem_rdata.key;
                    res_price_next = mem_rdata.price;
                    state_next     = S_DONE;
                end
            endcase
        end

        if (scan_miss)
        begin
            if (cmd_reg == CMD_INSERT)
            begin
                if (count_reg == CNT_W'(DEPTH))
                begin
                    res_status_next = STAT_FULL;
                    state_next      = S_DONE;
                end
                else
                begin
                    stop_next  = idx_reg;
                    idx_next   = count_reg;
                    state_next = S_SHIFT_RD;
                end
            end
            else
            begin
                res_status_next = STAT_NOT_FOUND;
                state_next      = S_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        price_reg      <= price_next;
        idx_reg        <= idx_next;
        stop_reg       <= stop_next;
        res_status_reg <= res_status_next;
        res_key_reg    <= res_key_next;
        res_price_reg  <= res_price_next;
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign result_valid = (state_reg == S_DONE);
    assign result.status = res_status_reg;
    assign result.key    = res_key_reg;
    assign result.price  = res_price_reg;
    assign result.count  = COUNT_W'(count_reg);

endmodule

/* rtl/skt_check.sv */
module skt_check
    import skt_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [STAT_W-1:0]   status,
    input logic [KEY_W-1:0]    key_out,
    input logic [PRICE_W-1:0]  price_out,
    input logic [COUNT_W-1:0]  count_out
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(key_out)
            && $stable(price_out) && $stable(count_out))
        else $error("result changed while stalled");

    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second command taken while one is in work");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_NOT_FOUND || status == STAT_EMPTY
            || status == STAT_DUPLICATE || status == STAT_FULL)
        |-> key_out == '0 && price_out == '0)
        else $error("failed command returned entry data");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> count_out <= COUNT_W'(DEPTH))
        else $error("entry count beyond table size");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STAT_FULL |-> count_out == COUNT_W'(DEPTH))
        else $error("full status with free entries");

endmodule

bind sorted_key_table skt_check u_check (.*);
